### src/lzw_byte_stream_encoder_assert.svh
// Assertion macros used by the dictionary engine.
`ifndef LZW_BYTE_STREAM_ENCODER_ASSERT_SVH
`define LZW_BYTE_STREAM_ENCODER_ASSERT_SVH
// The consequent holds in the same cycle as the antecedent.
`define LZW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define LZW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### src/lzw_pkg.sv
`default_nettype none
package lzw_pkg;
  localparam int unsigned START_WIDTH = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PROBE,
    ST_EMIT,
    ST_DRAIN
  } lzw_state_t;

  // One queued input item as classified by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } lzw_item_t;
endpackage
`default_nettype wire

### src/lzw_if.sv
`default_nettype none
interface lzw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface lzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       run_last;
  logic       stream_done;
  modport source (output valid, output packed_byte, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input packed_byte, input run_last, input stream_done,
                output ready);
endinterface
`default_nettype wire

### src/lzw_front.sv
`default_nettype none
// Input queue: two-entry FIFO that decouples the channel from the dictionary engine.
module lzw_front
  import lzw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  lzw_in_if.sink    in_ch,
  output lzw_item_t q_item,
  output logic      q_valid,
  input  wire logic q_pop
);
  lzw_item_t   mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r ^ push;
    rp_nxt = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= '{data_byte: in_ch.data_byte, stream_end: in_ch.stream_end};
    end
  end
endmodule
`default_nettype wire

### src/lzw_back.sv
`default_nettype none
// Dictionary engine: hashes, probes the slot memory, inserts and packs codes.
module lzw_back
  import lzw_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS   = 12,
  parameter int unsigned FIRST_FREE_CODE = 258,
  parameter int unsigned PROBE_MODULUS   = 4099,
  parameter int unsigned PROBE_STEP      = 13
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  lzw_item_t  q_item,
  input  wire logic  q_valid,
  output logic       q_pop,
  lzw_out_if.source  out_ch
);
  localparam int unsigned SW = $clog2(PROBE_MODULUS);
  localparam int unsigned KW = MAX_CODE_BITS + 8;
  localparam int unsigned CW = MAX_CODE_BITS;
  localparam int unsigned NW = MAX_CODE_BITS + 1;
  localparam int unsigned WW = $clog2(MAX_CODE_BITS + 2);
  localparam int unsigned EW = SW + 1;
  localparam int unsigned AW = 2 * MAX_CODE_BITS + 8;
  localparam logic [SW-1:0] MODV = SW'(PROBE_MODULUS);
  localparam logic [SW-1:0] STEPV = SW'(PROBE_STEP);
  localparam logic [SW:0] MODX = (SW+1)'(PROBE_MODULUS);
  // Reciprocal of the modulus, exact for every key below 2^KW.
  localparam logic [KW:0] RECIP =
    (KW+1)'((64'd1 << (KW + SW)) / 64'(PROBE_MODULUS) + 64'd1);

  lzw_state_t state_r, state_nxt;

  // Slot memory; used bits are epoch-free, cleared by a sweep.
  logic [KW-1:0] key_mem [PROBE_MODULUS];
  logic [CW-1:0] code_mem [PROBE_MODULUS];
  logic          used_mem [PROBE_MODULUS];
  logic [KW-1:0] rd_key_r;
  logic [CW-1:0] rd_code_r;
  logic          rd_used_r;
  logic [SW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en, wr_used;
  logic [KW-1:0] wr_key;
  logic [CW-1:0] wr_code;

  logic          pv_r, pv_nxt;
  logic [CW-1:0] prefix_r, prefix_nxt;
  logic [NW-1:0] nfc_r, nfc_nxt;
  logic [WW-1:0] width_r, width_nxt;
  logic [7:0]    pbits_r, pbits_nxt;
  logic [3:0]    pcnt_r, pcnt_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [EW-1:0] tries_r, tries_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic          wait_r, wait_nxt;
  // Code emission: up to two codes queued, packed from an accumulator.
  logic [AW-1:0] acc_r, acc_nxt;
  logic [5:0]    acnt_r, acnt_nxt;
  logic          flush_r, flush_nxt;
  logic          clrdict_r, clrdict_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          olast_r, olast_nxt, odone_r, odone_nxt;

  logic [SW:0]   home_w;
  logic [SW:0]   step_sum;

  assign out_ch.valid = ovalid_r;
  assign out_ch.packed_byte = obyte_r;
  assign out_ch.run_last = olast_r;
  assign out_ch.stream_done = odone_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_addr] <= wr_used;
      key_mem[wr_addr] <= wr_key;
      code_mem[wr_addr] <= wr_code;
    end
    if (rd_en) begin
      rd_used_r <= used_mem[rd_addr];
      rd_key_r <= key_mem[rd_addr];
      rd_code_r <= code_mem[rd_addr];
    end
  end

  // Home slot: key mod modulus by reciprocal multiplication, computed in steps:
  // the quotient first and the remainder next.
  logic [KW-1:0] rem_r, rem_nxt;
  logic          hashing_r, hashing_nxt;
  logic [4:0]    hbit_r, hbit_nxt;
  logic [SW:0]   hrem;
  logic [2*KW:0] qprod;
  assign home_w = {1'b0, rem_r[SW-1:0]};
  assign step_sum = {1'b0, slot_r} + {1'b0, STEPV};

  function automatic logic [AW-1:0] mask_code(logic [CW-1:0] c, logic [WW-1:0] w);
    logic [AW-1:0] m;
    m = (AW'(1) << w) - AW'(1);
    return AW'(c) & m;
  endfunction

  always_comb begin
    state_nxt = state_r;
    pv_nxt = pv_r; prefix_nxt = prefix_r; nfc_nxt = nfc_r; width_nxt = width_r;
    pbits_nxt = pbits_r; pcnt_nxt = pcnt_r; slot_nxt = slot_r; tries_nxt = tries_r;
    key_nxt = key_r; byte_nxt = byte_r; last_nxt = last_r; wait_nxt = 1'b0;
    acc_nxt = acc_r; acnt_nxt = acnt_r; flush_nxt = flush_r; clrdict_nxt = clrdict_r;
    clr_nxt = clr_r; ovalid_nxt = ovalid_r; obyte_nxt = obyte_r;
    olast_nxt = olast_r; odone_nxt = odone_r;
    rem_nxt = rem_r; hashing_nxt = hashing_r; hbit_nxt = hbit_r;
    hrem = '0;
    qprod = '0;
    q_pop = 1'b0;
    rd_en = 1'b0; rd_addr = slot_r;
    wr_en = 1'b0; wr_addr = slot_r; wr_used = 1'b0; wr_key = key_r;
    wr_code = nfc_r[CW-1:0];
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_r; wr_used = 1'b0;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == MODV - SW'(1)) begin
          clr_nxt = '0;
          state_nxt = clrdict_r ? ST_EMIT : ST_IDLE;
          clrdict_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          byte_nxt = q_item.data_byte;
          last_nxt = q_item.stream_end;
          if (!pv_r) begin
            if (q_item.stream_end) begin
              acc_nxt = mask_code(CW'(q_item.data_byte), width_r);
              acnt_nxt = 6'(width_r);
              flush_nxt = 1'b1;
              state_nxt = ST_EMIT;
            end else begin
              prefix_nxt = CW'(q_item.data_byte);
              pv_nxt = 1'b1;
            end
          end else if (q_item.stream_end) begin
            acc_nxt = (mask_code(prefix_r, width_r) << width_r)
                    | mask_code(CW'(q_item.data_byte), width_r);
            acnt_nxt = 6'(width_r) + 6'(width_r);
            flush_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            key_nxt = {prefix_r, q_item.data_byte};
            rem_nxt = {prefix_r, q_item.data_byte};
            hashing_nxt = 1'b1;
            hbit_nxt = 5'd1;
            tries_nxt = '0;
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (hashing_r) begin
          if (hbit_r != 5'd0) begin
            qprod = {{(KW+1){1'b0}}, rem_r} * {{KW{1'b0}}, RECIP};
            rem_nxt = KW'(qprod >> (KW + SW));
            hbit_nxt = 5'd0;
          end else begin
            rem_nxt = key_r - rem_r * KW'(PROBE_MODULUS);
            hashing_nxt = 1'b0;
          end
        end else if (tries_r == '0 && !wait_r) begin
          slot_nxt = home_w[SW-1:0];
          rd_en = 1'b1; rd_addr = home_w[SW-1:0];
          wait_nxt = 1'b1;
          tries_nxt = EW'(1);
        end else if (wait_r) begin
          if (!rd_used_r || rd_key_r != key_r) begin
            if (rd_used_r && tries_r == MODX[EW-1:0]) begin
              state_nxt = ST_DRAIN; // chain without an empty slot
            end else if (!rd_used_r) begin
              wr_en = 1'b1; wr_used = 1'b1; wr_addr = slot_r;
              state_nxt = ST_DRAIN;
            end else begin
              hrem = (step_sum >= MODX) ? step_sum - MODX : step_sum;
              slot_nxt = hrem[SW-1:0];
              rd_en = 1'b1; rd_addr = hrem[SW-1:0];
              wait_nxt = 1'b1;
              tries_nxt = tries_r + EW'(1);
            end
          end else begin
            prefix_nxt = rd_code_r;
            state_nxt = ST_IDLE;
          end
        end
        if (state_nxt == ST_DRAIN) begin
          acc_nxt = mask_code(prefix_r, width_r);
          acnt_nxt = 6'(width_r);
          prefix_nxt = CW'(byte_r);
          nfc_nxt = nfc_r + NW'(1);
          if (nfc_r + NW'(1) == (NW'(1) << width_r)) begin
            if (width_r == WW'(MAX_CODE_BITS)) begin
              clrdict_nxt = 1'b1;
              nfc_nxt = NW'(FIRST_FREE_CODE);
              width_nxt = WW'(START_WIDTH);
            end else begin
              width_nxt = width_r + WW'(1);
            end
          end
          state_nxt = ST_EMIT;
          if (clrdict_nxt) state_nxt = ST_CLEAR;
          // The code width used for emission is the old one; keep it in acc.
          acc_nxt = acc_nxt;
        end
      end
      ST_EMIT: begin
        // Merge pending bits ahead of the new codes once, then drain bytes.
        acc_nxt = acc_r | (AW'(pbits_r) << acnt_r);
        acnt_nxt = acnt_r + 6'(pcnt_r);
        pbits_nxt = '0; pcnt_nxt = '0;
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!ovalid_r || out_ch.ready) begin
          if (acnt_r >= 6'd8) begin
            ovalid_nxt = 1'b1;
            obyte_nxt = 8'(acc_r >> (acnt_r - 6'd8));
            acnt_nxt = acnt_r - 6'd8;
            olast_nxt = (acnt_r - 6'd8 < 6'd8) && !(flush_r && acnt_r != 6'd8);
            odone_nxt = flush_r && acnt_r == 6'd8;
          end else if (flush_r && acnt_r != 6'd0) begin
            ovalid_nxt = 1'b1;
            obyte_nxt = 8'(acc_r << (6'd8 - acnt_r));
            acnt_nxt = '0;
            olast_nxt = 1'b1;
            odone_nxt = 1'b1;
          end else begin
            pbits_nxt = 8'(acc_r & ((AW'(1) << acnt_r) - AW'(1)));
            pcnt_nxt = acnt_r[3:0];
            acc_nxt = '0; acnt_nxt = '0;
            if (flush_r) begin
              flush_nxt = 1'b0;
              pv_nxt = 1'b0; prefix_nxt = '0; pbits_nxt = '0; pcnt_nxt = '0;
              nfc_nxt = NW'(FIRST_FREE_CODE); width_nxt = WW'(START_WIDTH);
              state_nxt = ST_CLEAR;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      pv_r <= 1'b0; prefix_r <= '0; nfc_r <= NW'(FIRST_FREE_CODE);
      width_r <= WW'(START_WIDTH); pbits_r <= '0; pcnt_r <= '0;
      clr_r <= '0; clrdict_r <= 1'b0; flush_r <= 1'b0; ovalid_r <= 1'b0;
      wait_r <= 1'b0; hashing_r <= 1'b0; acnt_r <= '0; tries_r <= '0;
    end else begin
      state_r <= state_nxt;
      pv_r <= pv_nxt; prefix_r <= prefix_nxt; nfc_r <= nfc_nxt; width_r <= width_nxt;
      pbits_r <= pbits_nxt; pcnt_r <= pcnt_nxt; clr_r <= clr_nxt;
      clrdict_r <= clrdict_nxt; flush_r <= flush_nxt; ovalid_r <= ovalid_nxt;
      wait_r <= wait_nxt; hashing_r <= hashing_nxt; acnt_r <= acnt_nxt;
      tries_r <= tries_nxt;
    end
    slot_r <= slot_nxt; key_r <= key_nxt; byte_r <= byte_nxt; last_r <= last_nxt;
    acc_r <= acc_nxt; obyte_r <= obyte_nxt; olast_r <= olast_nxt; odone_r <= odone_nxt;
    rem_r <= rem_nxt; hbit_r <= hbit_nxt;
  end

  `include "lzw_byte_stream_encoder_assert.svh"
  `LZW_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
                   out_ch.valid && $stable(out_ch.packed_byte))
  `LZW_ASSERT_SAME(a_done_last, clk, rst_n, out_ch.valid && out_ch.stream_done,
                   out_ch.run_last)
  `LZW_ASSERT_SAME(a_pop_idle, clk, rst_n, q_pop, state_r == ST_IDLE)
  `LZW_ASSERT_SAME(a_pend, clk, rst_n, 1'b1, pcnt_r < 4'd8)
endmodule
`default_nettype wire

### src/lzw_byte_stream_encoder.sv
// A hit in the home slot goes through the pop, the quotient and remainder steps, read and compare.
// Each byte's probes, and on a miss its output bytes, are issued before the engine pops the next byte.
// The slot memory read port serializes probes; output bytes leave one per cycle while the receiver is ready.
// Reset: synchronous active-low; then a clearing pass over all PROBE_MODULUS slots runs before
// the engine pops any byte from the queue, and again after each dictionary reset or stream end.
`default_nettype none
module lzw_byte_stream_encoder
  import lzw_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS   = 12,
  parameter int unsigned FIRST_FREE_CODE = 258,
  parameter int unsigned PROBE_MODULUS   = 4099,
  parameter int unsigned PROBE_STEP      = 13
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch
);
  lzw_item_t q_item;
  logic      q_valid, q_pop;

  lzw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
  );

  lzw_back #(
    .MAX_CODE_BITS(MAX_CODE_BITS), .FIRST_FREE_CODE(FIRST_FREE_CODE),
    .PROBE_MODULUS(PROBE_MODULUS), .PROBE_STEP(PROBE_STEP)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_item(q_item), .q_valid(q_valid),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import lzw_pkg::*;

  localparam int unsigned MAX_BITS   = 12;
  localparam int unsigned FIRST_CODE = 258;
  localparam int unsigned MODULUS    = 4099;
  localparam int unsigned STEP       = 13;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [7:0] packed_byte;
    logic       run_last;
    logic       stream_done;
  } code_byte_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       stream_end;
    int         n_typed;
    logic [7:0] typed0;
    logic [7:0] typed1;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   fail_count;

  lzw_in_if  in_ch ();
  lzw_out_if out_ch ();

  lzw_byte_stream_encoder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Encoder state as the bench tracks it.
  bit          have_prefix;
  int unsigned prefix_code;
  int unsigned free_code;
  int unsigned width_bits;
  int unsigned bit_buf;
  int unsigned bit_cnt;
  bit          dict_used [MODULUS];
  int unsigned dict_key [MODULUS];
  int unsigned dict_code [MODULUS];

  code_byte_t  expected_bytes[$];
  code_byte_t  step_bytes[$];

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_dict();
    for (int i = 0; i < MODULUS; i++) dict_used[i] = 1'b0;
    free_code  = FIRST_CODE;
    width_bits = START_WIDTH;
  endfunction

  function automatic void encoder_reset();
    have_prefix = 1'b0;
    prefix_code = 0;
    bit_buf     = 0;
    bit_cnt     = 0;
    clear_dict();
  endfunction

  function automatic void pack_code(int unsigned code);
    int unsigned acc;
    code_byte_t  b;
    acc = (bit_buf << width_bits) | (code & ((32'd1 << width_bits) - 1));
    bit_cnt += width_bits;
    while (bit_cnt >= 8) begin
      b.packed_byte = 8'((acc >> (bit_cnt - 8)) & 8'hFF);
      b.run_last    = 1'b0;
      b.stream_done = 1'b0;
      step_bytes.push_back(b);
      bit_cnt -= 8;
    end
    bit_buf = acc & ((32'd1 << bit_cnt) - 1);
  endfunction

  function automatic void flush_tail();
    code_byte_t b;
    if (bit_cnt > 0) begin
      b.packed_byte = 8'((bit_buf << (8 - bit_cnt)) & 8'hFF);
      b.run_last    = 1'b0;
      b.stream_done = 1'b1;
      step_bytes.push_back(b);
    end else if (step_bytes.size() > 0) begin
      step_bytes[step_bytes.size() - 1].stream_done = 1'b1;
    end
  endfunction

  // Computes the packed bytes caused by one input byte into step_bytes.
  function automatic void encode_byte(logic [7:0] data, logic last);
    int unsigned key;
    int unsigned slot;
    int unsigned hole;
    bit          hit;
    step_bytes.delete();
    if (!have_prefix) begin
      if (last) begin
        pack_code(data);
        flush_tail();
        encoder_reset();
      end else begin
        prefix_code = data;
        have_prefix = 1'b1;
      end
    end else if (last) begin
      pack_code(prefix_code);
      pack_code(data);
      flush_tail();
      encoder_reset();
    end else begin
      key  = (prefix_code << 8) | data;
      slot = key % MODULUS;
      hit  = 1'b0;
      hole = MODULUS;
      for (int n = 0; n < MODULUS; n++) begin
        if (!dict_used[slot]) begin
          hole = slot;
          break;
        end
        if (dict_key[slot] == key) begin
          hit = 1'b1;
          prefix_code = dict_code[slot];
          break;
        end
        slot = (slot + STEP) % MODULUS;
      end
      if (!hit) begin
        if (hole < MODULUS) begin
          dict_used[hole] = 1'b1;
          dict_key[hole]  = key;
          dict_code[hole] = free_code;
        end
        pack_code(prefix_code);
        free_code++;
        if (free_code == (32'd1 << width_bits)) begin
          width_bits++;
          if (width_bits == MAX_BITS + 1) clear_dict();
        end
        prefix_code = data;
      end
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].run_last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] data, logic last, int gap, int n_typed,
                           logic [7:0] t0, logic [7:0] t1);
    code_byte_t b;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.stream_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    encode_byte(data, last);
    if (n_typed > 0) begin
      // Single-byte streams: one 9-bit code, then one padded byte.
      b.packed_byte = t0; b.run_last = 1'b0; b.stream_done = 1'b0;
      expected_bytes.push_back(b);
      b.packed_byte = t1; b.run_last = 1'b1; b.stream_done = 1'b1;
      expected_bytes.push_back(b);
    end else begin
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
    end
    @(negedge clk);
  endtask

  function automatic int draw_gap(int phase);
    if (phase % 3 == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  stim_row_t directed[$];

  function automatic void add_row(logic [7:0] d, logic e, int n = 0,
                                  logic [7:0] t0 = 8'h00, logic [7:0] t1 = 8'h00);
    stim_row_t r;
    r.data_byte = d; r.stream_end = e; r.n_typed = n; r.typed0 = t0; r.typed1 = t1;
    directed.push_back(r);
  endfunction

  // Stimulus.
  initial begin
    int          sent;
    int          len;
    int          alpha;
    int          phase;
    logic [7:0]  d;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.stream_end = 1'b0;
    rst_n = 1'b0;
    encoder_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(8'hFF, 1'b1, 2, 8'h7F, 8'h80);
    add_row(8'h00, 1'b1, 2, 8'h00, 8'h00);
    add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'h41, 1'b1);
    for (int i = 0; i < 7; i++) add_row(8'h55, 1'b0);
    add_row(8'h55, 1'b1);
    // The pair (16, 6) lands in the home slot already taken by (0, 3).
    add_row(8'h00, 1'b0); add_row(8'h03, 1'b0); add_row(8'h10, 1'b0);
    add_row(8'h06, 1'b0); add_row(8'hAA, 1'b1);
    add_row(8'h80, 1'b0); add_row(8'h01, 1'b1);

    phase = 1;
    foreach (directed[i])
      send_byte(directed[i].data_byte, directed[i].stream_end, draw_gap(phase),
                directed[i].n_typed, directed[i].typed0, directed[i].typed1);

    sent = 0;
    while (sent < 250) begin
      phase++;
      len   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 6);
      for (int i = 0; i < len; i++) begin
        d = (alpha == 256) ? 8'($urandom_range(0, 255))
                           : 8'($urandom_range(0, alpha - 1) + 8'h61);
        send_byte(d, i == len - 1, draw_gap(phase), 0, 8'h00, 8'h00);
        sent++;
      end
      if (phase == 6) begin
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() > 0) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_bytes.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stalls, with stretches of none.
  initial begin
    int gap;
    int n;
    out_ch.ready = 1'b0;
    n = 0;
    forever begin
      gap = ((n / 40) % 3 == 0) ? 0 : $urandom_range(0, 18);
      n++;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    code_byte_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction: packed_byte %0h", out_ch.packed_byte);
        fail_count++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_ch.packed_byte !== e.packed_byte) begin
          $error("packed_byte: expected %0h, got %0h", e.packed_byte, out_ch.packed_byte);
          fail_count++;
        end
        if (out_ch.run_last !== e.run_last) begin
          $error("run_last: expected %0b, got %0b", e.run_last, out_ch.run_last);
          fail_count++;
        end
        if (out_ch.stream_done !== e.stream_done) begin
          $error("stream_done: expected %0b, got %0b", e.stream_done, out_ch.stream_done);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule
